@@ src/hex_cell_to_five_tetrahedra_assert.svh @@
// assertion macros for the hex cell splitter rtl
// depends on nothing; included by modules that carry concurrent checks
`ifndef HEX_CELL_TO_FIVE_TETRAHEDRA_ASSERT_SVH
`define HEX_CELL_TO_FIVE_TETRAHEDRA_ASSERT_SVH

// same-cycle implication, disabled in reset
`define HCTT_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("hctt check failed");

// next-cycle implication, disabled in reset
`define HCTT_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("hctt check failed");

`endif

@@ src/hctt_pkg.sv @@
// types, widths and corner templates for the hex cell splitter
// no dependencies; used by the interfaces and all modules
package hctt_pkg;

  localparam int COORD_W       = 10;
  localparam int MAT_W         = 4;
  localparam int NODE_W        = 32;
  localparam int CORNERS       = 8;
  localparam int CORNER_W      = 3;
  localparam int TETS_PER_CELL = 5;
  localparam int TET_IDX_W     = 3;

  localparam logic [MAT_W-1:0]     MIXED_RESET = 4'd3;
  localparam logic [TET_IDX_W-1:0] LAST_TET    = 3'(TETS_PER_CELL - 1);

  // corner numbers per tetrahedron, c = dx + 2*dy + 4*dz
  // first index: parity of x+y+z
  localparam logic [CORNER_W-1:0] TET_TEMPLATE [2][TETS_PER_CELL][4] = '{
    '{ '{3'd0, 3'd1, 3'd3, 3'd5}, '{3'd0, 3'd2, 3'd3, 3'd6}, '{3'd0, 3'd4, 3'd5, 3'd6},
       '{3'd3, 3'd5, 3'd6, 3'd7}, '{3'd0, 3'd3, 3'd5, 3'd6} },
    '{ '{3'd0, 3'd1, 3'd2, 3'd4}, '{3'd1, 3'd2, 3'd3, 3'd7}, '{3'd1, 3'd4, 3'd5, 3'd7},
       '{3'd2, 3'd4, 3'd6, 3'd7}, '{3'd1, 3'd2, 3'd4, 3'd7} }
  };

  typedef struct packed {
    logic                              parity;
    logic [CORNERS-1:0][MAT_W-1:0]     mats;
    logic [CORNERS-1:0][NODE_W-1:0]    nodes;
  } cell_t;

  typedef struct packed {
    logic [MAT_W-1:0]  tet_material;
    logic [NODE_W-1:0] vertex_a;
    logic [NODE_W-1:0] vertex_b;
    logic [NODE_W-1:0] vertex_c;
    logic [NODE_W-1:0] vertex_d;
    logic              last_tet;
  } tet_t;

endpackage

@@ src/hctt_cell_if.sv @@
// input channel carrying one grid cell
// depends on hctt_pkg
interface hctt_cell_if;
  logic                          valid;
  logic                          ready;
  logic [hctt_pkg::COORD_W-1:0]  cell_x;
  logic [hctt_pkg::COORD_W-1:0]  cell_y;
  logic [hctt_pkg::COORD_W-1:0]  cell_z;
  logic [31:0]                   corner_materials;
  logic [hctt_pkg::NODE_W-1:0]   corner_node_0;
  logic [hctt_pkg::NODE_W-1:0]   corner_node_1;
  logic [hctt_pkg::NODE_W-1:0]   corner_node_2;
  logic [hctt_pkg::NODE_W-1:0]   corner_node_3;
  logic [hctt_pkg::NODE_W-1:0]   corner_node_4;
  logic [hctt_pkg::NODE_W-1:0]   corner_node_5;
  logic [hctt_pkg::NODE_W-1:0]   corner_node_6;
  logic [hctt_pkg::NODE_W-1:0]   corner_node_7;

  modport source (output valid, cell_x, cell_y, cell_z, corner_materials,
                  corner_node_0, corner_node_1, corner_node_2, corner_node_3,
                  corner_node_4, corner_node_5, corner_node_6, corner_node_7,
                  input ready);
  modport sink (input valid, cell_x, cell_y, cell_z, corner_materials,
                corner_node_0, corner_node_1, corner_node_2, corner_node_3,
                corner_node_4, corner_node_5, corner_node_6, corner_node_7,
                output ready);
endinterface

@@ src/hctt_tet_if.sv @@
// output channel carrying one tetrahedron
// depends on hctt_pkg
interface hctt_tet_if;
  logic                         valid;
  logic                         ready;
  logic [hctt_pkg::MAT_W-1:0]   tet_material;
  logic [hctt_pkg::NODE_W-1:0]  vertex_a;
  logic [hctt_pkg::NODE_W-1:0]  vertex_b;
  logic [hctt_pkg::NODE_W-1:0]  vertex_c;
  logic [hctt_pkg::NODE_W-1:0]  vertex_d;
  logic                         last_tet;

  modport source (output valid, tet_material, vertex_a, vertex_b, vertex_c, vertex_d,
                  last_tet, input ready);
  modport sink (input valid, tet_material, vertex_a, vertex_b, vertex_c, vertex_d,
                last_tet, output ready);
endinterface

@@ src/hctt_tet_gen.sv @@
// builds one tetrahedron from a held cell and a tetrahedron index
// depends on hctt_pkg (templates, cell_t, tet_t)
module hctt_tet_gen (
  input  hctt_pkg::cell_t                       grid_cell,
  input  logic [hctt_pkg::TET_IDX_W-1:0]        tet_idx,
  input  logic [hctt_pkg::MAT_W-1:0]            mixed_code,
  output hctt_pkg::tet_t                        tet
);

  logic [hctt_pkg::CORNER_W-1:0] corner [4];
  logic [hctt_pkg::MAT_W-1:0]    mat [4];
  logic [hctt_pkg::NODE_W-1:0]   node [4];
  logic                          same;

  // look up the four corners and fetch their material and node number
  always_comb begin
    for (int v = 0; v < 4; v++) begin
      corner[v] = hctt_pkg::TET_TEMPLATE[grid_cell.parity][tet_idx][v];
      mat[v]    = grid_cell.mats[corner[v]];
      node[v]   = grid_cell.nodes[corner[v]];
    end
  end

  // uniform material check
  assign same = (mat[1] == mat[0]) && (mat[2] == mat[0]) && (mat[3] == mat[0]);

  always_comb begin
    tet.tet_material = same ? mat[0] : mixed_code;
    tet.vertex_a     = node[0];
    tet.vertex_b     = node[1];
    tet.vertex_c     = node[2];
    tet.vertex_d     = node[3];
    tet.last_tet     = (tet_idx == hctt_pkg::LAST_TET);
  end

endmodule

@@ src/hex_cell_to_five_tetrahedra.sv @@
// splits one hexahedral grid cell into five tetrahedra, one per output transfer
// the first tetrahedron passes through the held cell register, then the result register
// the held cell emits its five tetrahedra one at a time through the single output channel;
// the next cell is taken in the cycle its predecessor's fifth tetrahedron loads
// reset (synchronous, active high) empties both registers and sets the mixed code to 3
// depends on hctt_pkg, hctt_cell_if, hctt_tet_if, hctt_tet_gen, assertion header
`include "hex_cell_to_five_tetrahedra_assert.svh"

module hex_cell_to_five_tetrahedra (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_write,
  input  logic [hctt_pkg::MAT_W-1:0]  cfg_data,
  hctt_cell_if.sink                   cell_in,
  hctt_tet_if.source                  tet_out
);

  logic [hctt_pkg::MAT_W-1:0]     mixed_code;
  hctt_pkg::cell_t                held;
  logic                           held_valid;
  logic [hctt_pkg::TET_IDX_W-1:0] tet_idx;
  hctt_pkg::tet_t                 out_tet;
  logic                           out_valid;
  hctt_pkg::tet_t                 tet_next;
  hctt_pkg::cell_t                cell_next;
  logic                           out_free;
  logic                           advance;
  logic                           held_done;
  logic                           cell_take;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      mixed_code <= hctt_pkg::MIXED_RESET;
    end else if (cfg_write) begin
      mixed_code <= cfg_data;
    end
  end

  // input cell, only the parity of the coordinate sum is kept
  always_comb begin
    cell_next.parity = cell_in.cell_x[0] ^ cell_in.cell_y[0] ^ cell_in.cell_z[0];
    cell_next.mats   = cell_in.corner_materials;
    cell_next.nodes  = {cell_in.corner_node_7, cell_in.corner_node_6,
                        cell_in.corner_node_5, cell_in.corner_node_4,
                        cell_in.corner_node_3, cell_in.corner_node_2,
                        cell_in.corner_node_1, cell_in.corner_node_0};
  end

  // handshake control
  assign out_free      = !out_valid || tet_out.ready;
  assign advance       = held_valid && out_free;
  assign held_done     = advance && (tet_idx == hctt_pkg::LAST_TET);
  assign cell_in.ready = !held_valid || held_done;
  assign cell_take     = cell_in.valid && cell_in.ready;

  hctt_tet_gen u_tet_gen (
    .grid_cell  (held),
    .tet_idx    (tet_idx),
    .mixed_code (mixed_code),
    .tet        (tet_next)
  );

  // held cell and tetrahedron counter
  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
      tet_idx    <= '0;
    end else if (cell_take) begin
      held_valid <= 1'b1;
      tet_idx    <= '0;
    end else if (held_done) begin
      held_valid <= 1'b0;
    end else if (advance) begin
      tet_idx <= tet_idx + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cell_take) begin
      held <= cell_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= held_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_tet <= tet_next;
    end
  end

  assign tet_out.valid        = out_valid;
  assign tet_out.tet_material = out_tet.tet_material;
  assign tet_out.vertex_a     = out_tet.vertex_a;
  assign tet_out.vertex_b     = out_tet.vertex_b;
  assign tet_out.vertex_c     = out_tet.vertex_c;
  assign tet_out.vertex_d     = out_tet.vertex_d;
  assign tet_out.last_tet     = out_tet.last_tet;

  // checks
  `HCTT_ASSERT_NEXT(a_take_starts, clk, rst, cell_take, held_valid && (tet_idx == '0))
  `HCTT_ASSERT_NEXT(a_no_drop, clk, rst, advance && !held_done, held_valid)
  `HCTT_ASSERT_NOW(a_idx_range, clk, rst, held_valid, tet_idx <= hctt_pkg::LAST_TET)
  `HCTT_ASSERT_NOW(a_ready_at_end, clk, rst, cell_in.ready && held_valid, held_done)
  `HCTT_ASSERT_NEXT(a_last_flag, clk, rst, held_done, out_valid && out_tet.last_tet)

endmodule

@@ tb/sv/hex_cell_to_five_tetrahedra_test.sv @@
// self-checking testbench for hex_cell_to_five_tetrahedra: cells in, tetrahedra out
// depends on hctt_pkg, hctt_cell_if, hctt_tet_if and the block's rtl
module hex_cell_to_five_tetrahedra_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [3:0] MIXED_AT_RESET = 4'd3;
  localparam int unsigned MAX_WAIT = 18;
  localparam int unsigned TETS = 5;
  localparam int unsigned RANDOM_PHASES = 5;
  localparam int unsigned CELLS_PER_PHASE = 50;
  localparam int unsigned PRINT_CAP = 40;

  // corner numbers per tetrahedron, c = dx + 2*dy + 4*dz
  localparam logic [0:4][0:3][2:0] EVEN_CORNERS = {
    3'd0, 3'd1, 3'd3, 3'd5,  3'd0, 3'd2, 3'd3, 3'd6,  3'd0, 3'd4, 3'd5, 3'd6,
    3'd3, 3'd5, 3'd6, 3'd7,  3'd0, 3'd3, 3'd5, 3'd6
  };
  localparam logic [0:4][0:3][2:0] ODD_CORNERS = {
    3'd0, 3'd1, 3'd2, 3'd4,  3'd1, 3'd2, 3'd3, 3'd7,  3'd1, 3'd4, 3'd5, 3'd7,
    3'd2, 3'd4, 3'd6, 3'd7,  3'd1, 3'd2, 3'd4, 3'd7
  };

  typedef enum int {
    MATS_NOISE,
    MATS_ONE_VALUE,
    MATS_TWO_VALUES,
    MATS_ONE_TET
  } mat_pattern_t;

  typedef struct packed {
    logic [9:0]       x;
    logic [9:0]       y;
    logic [9:0]       z;
    logic [31:0]      mats;
    logic [7:0][31:0] node;
  } grid_cell_t;

  logic       clk;
  logic       rst;
  logic       cfg_write;
  logic [3:0] cfg_data;

  hctt_cell_if cell_ch ();
  hctt_tet_if  tet_ch ();

  hex_cell_to_five_tetrahedra uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .cell_in   (cell_ch),
    .tet_out   (tet_ch)
  );

  // tetrahedra still to arrive, oldest first
  hctt_pkg::tet_t pending_tets [$];
  logic [3:0]     mixed_code;
  bit             src_idle_on;
  bit             snk_idle_on;

  int unsigned mismatch_count;
  int unsigned cells_sent;
  int unsigned odd_cells;
  int unsigned tets_checked;
  int unsigned uniform_tets;
  int unsigned mixed_tets;
  int unsigned code_writes;

  initial clk = 1'b0;
  always #4 clk = ~clk;

  function automatic logic [2:0] split_corner(bit odd, int t, int v);
    return odd ? ODD_CORNERS[t][v] : EVEN_CORNERS[t][v];
  endfunction

  function automatic logic [3:0] corner_mat(logic [31:0] mats, logic [2:0] c);
    return mats[int'(c) * 4 +: 4];
  endfunction

  function automatic int unsigned draw_wait(bit on);
    return on ? $urandom_range(0, MAX_WAIT) : 0;
  endfunction

  // five tetrahedra of one cell, queued in output order
  function automatic void split_cell(grid_cell_t c);
    hctt_pkg::tet_t tet;
    logic [3:0]     first;
    logic [2:0]     k;
    bit             odd;
    bit             uniform;
    logic [31:0]    vtx [4];
    odd = c.x[0] ^ c.y[0] ^ c.z[0];
    if (odd) odd_cells++;
    for (int t = 0; t < TETS; t++) begin
      first = corner_mat(c.mats, split_corner(odd, t, 0));
      uniform = 1'b1;
      for (int v = 0; v < 4; v++) begin
        k = split_corner(odd, t, v);
        if (corner_mat(c.mats, k) != first) uniform = 1'b0;
        vtx[v] = c.node[k];
      end
      if (uniform) uniform_tets++;
      else mixed_tets++;
      tet.tet_material = uniform ? first : mixed_code;
      tet.vertex_a     = vtx[0];
      tet.vertex_b     = vtx[1];
      tet.vertex_c     = vtx[2];
      tet.vertex_d     = vtx[3];
      tet.last_tet     = (t == TETS - 1);
      pending_tets = {pending_tets, tet};
    end
  endfunction

  function automatic grid_cell_t make_cell(logic [9:0] x, logic [9:0] y, logic [9:0] z,
                                           logic [31:0] mats, logic [31:0] base,
                                           logic [31:0] step);
    grid_cell_t c;
    c.x = x;
    c.y = y;
    c.z = z;
    c.mats = mats;
    for (int k = 0; k < 8; k++) c.node[k] = base + step * k;
    return c;
  endfunction

  // random coordinates and nodes, materials shaped so uniform tetrahedra show up often
  function automatic grid_cell_t make_random_cell();
    grid_cell_t c;
    logic [3:0] a;
    logic [3:0] b;
    bit         odd;
    int         t;
    c.x = 10'($urandom_range(0, 1023));
    c.y = 10'($urandom_range(0, 1023));
    c.z = 10'($urandom_range(0, 1023));
    for (int k = 0; k < 8; k++) c.node[k] = $urandom();
    a = 4'($urandom_range(0, 15));
    b = 4'($urandom_range(0, 15));
    case (mat_pattern_t'($urandom_range(MATS_NOISE, MATS_ONE_TET)))
      MATS_NOISE: c.mats = $urandom();
      MATS_ONE_VALUE: c.mats = {8{a}};
      MATS_TWO_VALUES: begin
        for (int k = 0; k < 8; k++) c.mats[k * 4 +: 4] = $urandom_range(0, 1) ? a : b;
      end
      default: begin
        c.mats = $urandom();
        odd = c.x[0] ^ c.y[0] ^ c.z[0];
        t = $urandom_range(0, TETS - 1);
        for (int v = 0; v < 4; v++) c.mats[int'(split_corner(odd, t, v)) * 4 +: 4] = a;
      end
    endcase
    return c;
  endfunction

  task automatic report_mismatch(input string msg);
    if (mismatch_count < PRINT_CAP) $display("mismatch: %s", msg);
    mismatch_count++;
  endtask

  // one cell transfer; entered and left at a falling edge
  task automatic send_cell(input grid_cell_t c);
    int unsigned gap;
    gap = draw_wait(src_idle_on);
    if (gap != 0) begin
      cell_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    cell_ch.cell_x           = c.x;
    cell_ch.cell_y           = c.y;
    cell_ch.cell_z           = c.z;
    cell_ch.corner_materials = c.mats;
    cell_ch.corner_node_0    = c.node[0];
    cell_ch.corner_node_1    = c.node[1];
    cell_ch.corner_node_2    = c.node[2];
    cell_ch.corner_node_3    = c.node[3];
    cell_ch.corner_node_4    = c.node[4];
    cell_ch.corner_node_5    = c.node[5];
    cell_ch.corner_node_6    = c.node[6];
    cell_ch.corner_node_7    = c.node[7];
    cell_ch.valid            = 1'b1;
    do @(posedge clk); while (cell_ch.ready !== 1'b1);
    split_cell(c);
    cells_sent++;
    @(negedge clk);
  endtask

  // stop sending, wait until every tetrahedron is back, then let the clock run on
  task automatic drain_outputs();
    cell_ch.valid = 1'b0;
    while (pending_tets.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_mixed_code(input logic [3:0] code);
    drain_outputs();
    cfg_write = 1'b1;
    cfg_data  = code;
    @(negedge clk);
    cfg_write = 1'b0;
    mixed_code = code;
    code_writes++;
  endtask

  // compare one tetrahedron transfer against the oldest pending one
  task automatic check_tet();
    hctt_pkg::tet_t want;
    tets_checked++;
    if (pending_tets.size() == 0) begin
      report_mismatch($sformatf("tetrahedron %0d arrived with none pending", tets_checked));
      return;
    end
    want = pending_tets.pop_front();
    if (tet_ch.tet_material !== want.tet_material)
      report_mismatch($sformatf("tet %0d material got %h want %h", tets_checked,
                                tet_ch.tet_material, want.tet_material));
    if (tet_ch.vertex_a !== want.vertex_a)
      report_mismatch($sformatf("tet %0d vertex_a got %h want %h", tets_checked,
                                tet_ch.vertex_a, want.vertex_a));
    if (tet_ch.vertex_b !== want.vertex_b)
      report_mismatch($sformatf("tet %0d vertex_b got %h want %h", tets_checked,
                                tet_ch.vertex_b, want.vertex_b));
    if (tet_ch.vertex_c !== want.vertex_c)
      report_mismatch($sformatf("tet %0d vertex_c got %h want %h", tets_checked,
                                tet_ch.vertex_c, want.vertex_c));
    if (tet_ch.vertex_d !== want.vertex_d)
      report_mismatch($sformatf("tet %0d vertex_d got %h want %h", tets_checked,
                                tet_ch.vertex_d, want.vertex_d));
    if (tet_ch.last_tet !== want.last_tet)
      report_mismatch($sformatf("tet %0d last flag got %b want %b", tets_checked,
                                tet_ch.last_tet, want.last_tet));
  endtask

  // output side: random stall before each transfer when sink idling is on, then check it
  initial begin : tet_receiver
    int unsigned stall;
    tet_ch.ready = 1'b0;
    do @(posedge clk); while (rst !== 1'b0);
    @(negedge clk);
    forever begin
      stall = draw_wait(snk_idle_on);
      if (stall != 0) begin
        tet_ch.ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      tet_ch.ready = 1'b1;
      do @(posedge clk); while (tet_ch.valid !== 1'b1);
      check_tet();
      @(negedge clk);
    end
  end

  // field extremes, both parities, each tetrahedron uniform on its own, reset mixed code
  task automatic test_directed_cells();
    grid_cell_t c;
    src_idle_on = 1'b1;
    snk_idle_on = 1'b1;
    send_cell(make_cell(10'd0, 10'd0, 10'd0, 32'h0, 32'h0, 32'h0));
    send_cell(make_cell(10'd1023, 10'd1023, 10'd1023, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0));
    send_cell(make_cell(10'd0, 10'd0, 10'd0, 32'h7654_3210, 32'h1000_0000, 32'h1));
    send_cell(make_cell(10'd1023, 10'd0, 10'd0, 32'h7654_3210, 32'hFFFF_FFF8, 32'h1));
    send_cell(make_cell(10'd682, 10'd341, 10'd0, 32'h5555_5555, 32'hAAAA_AAAA, 32'h0));
    // repeated node numbers throughout the cell
    send_cell(make_cell(10'd0, 10'd1, 10'd1, 32'hAAAA_5555, 32'h0000_0001, 32'h0));
    for (int odd = 0; odd < 2; odd++) begin
      for (int t = 0; t < TETS; t++) begin
        c = make_cell(10'(odd), 10'd512, 10'd0, 32'h7654_3210, 32'h8000_0000 + t * 16, 32'h1);
        for (int v = 0; v < 4; v++) c.mats[int'(split_corner(odd, t, v)) * 4 +: 4] = 4'hC;
        send_cell(c);
      end
    end
    drain_outputs();
  endtask

  // mixed code at both extremes and two patterns, no idling on either side
  task automatic test_mixed_code_writes();
    logic [3:0] codes [4];
    codes = '{4'd0, 4'd15, 4'd9, 4'd6};
    src_idle_on = 1'b0;
    snk_idle_on = 1'b0;
    foreach (codes[i]) begin
      write_mixed_code(codes[i]);
      send_cell(make_cell(10'd2, 10'd4, 10'd6, 32'hF0F0_0F0F, 32'h0123_4567, 32'h1111_1111));
      send_cell(make_cell(10'd3, 10'd4, 10'd6, 32'h8888_8881, 32'hFEDC_BA98, 32'h0101_0101));
    end
    drain_outputs();
  endtask

  // random cells in phases, a fresh mixed code per phase and a fresh idling pattern every ten cells
  task automatic test_random_cells();
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      write_mixed_code(4'($urandom_range(0, 15)));
      for (int n = 0; n < CELLS_PER_PHASE; n++) begin
        if (n % 10 == 0) begin
          src_idle_on = ($urandom_range(0, 2) != 0);
          snk_idle_on = ($urandom_range(0, 2) != 0);
        end
        send_cell(make_random_cell());
      end
    end
    drain_outputs();
  endtask

  initial begin : stimulus
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_data = 4'd0;
    cell_ch.valid = 1'b0;
    cell_ch.cell_x = '0;
    cell_ch.cell_y = '0;
    cell_ch.cell_z = '0;
    cell_ch.corner_materials = '0;
    cell_ch.corner_node_0 = '0;
    cell_ch.corner_node_1 = '0;
    cell_ch.corner_node_2 = '0;
    cell_ch.corner_node_3 = '0;
    cell_ch.corner_node_4 = '0;
    cell_ch.corner_node_5 = '0;
    cell_ch.corner_node_6 = '0;
    cell_ch.corner_node_7 = '0;
    mixed_code = MIXED_AT_RESET;
    src_idle_on = 1'b0;
    snk_idle_on = 1'b0;
    repeat (6) @(negedge clk);
    rst = 1'b0;

    test_directed_cells();
    test_mixed_code_writes();
    test_random_cells();

    // wrap-up
    repeat (10) @(negedge clk);
    $display("covered %0d cells (%0d odd parity), %0d tetrahedra checked",
             cells_sent, odd_cells, tets_checked);
    $display("%0d uniform and %0d mixed-material tetrahedra, %0d mixed code writes",
             uniform_tets, mixed_tets, code_writes);
    if (mismatch_count == 0 && pending_tets.size() == 0) begin
      $display("hex_cell_to_five_tetrahedra_test: PASS");
    end else begin
      $display("hex_cell_to_five_tetrahedra_test: FAIL");
    end
    $finish;
  end

  // watchdog far above the slowest legal run
  initial begin : watchdog
    #2_000_000;
    $display("timeout with %0d tetrahedra pending", pending_tets.size());
    $display("hex_cell_to_five_tetrahedra_test: FAIL");
    $finish;
  end

endmodule
